### rtl/core/vca_pkg.sv
// vca_pkg: shared types, codes and constants of the valve command arbiter
// no dependencies
package vca_pkg;

  localparam int unsigned ScaleShift = 17;
  localparam int unsigned ScaleMul   = 131;
  localparam int unsigned QDepth     = 2;

  // register indexes of the configuration port
  localparam logic [3:0] REG_CONTROL_MODE  = 4'd0;
  localparam logic [3:0] REG_REMOTE_SOURCE = 4'd1;
  localparam logic [3:0] REG_BREAK_MODE    = 4'd2;
  localparam logic [3:0] REG_FULL_TRAVEL   = 4'd3;
  localparam logic [3:0] REG_DEAD_BAND     = 4'd4;
  localparam logic [3:0] REG_BREAK_EXTRA   = 4'd5;
  localparam logic [3:0] REG_SEAL_UNLOCKED = 4'd6;
  localparam logic [3:0] REG_LOCAL_DIGITAL = 4'd7;

  localparam logic [1:0] MODE_ANALOG = 2'd0;
  localparam logic [1:0] MODE_SWITCH = 2'd1;
  localparam logic [1:0] MODE_LOCAL  = 2'd2;

  localparam logic [1:0] RSRC_BOTH    = 2'd0;
  localparam logic [1:0] RSRC_DIGITAL = 2'd1;
  localparam logic [1:0] RSRC_SERIAL  = 2'd2;

  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_HALT = 2'd1;

  // control word codes
  localparam logic [2:0] CW_NONE   = 3'd0;
  localparam logic [2:0] CW_STOP   = 3'd1;
  localparam logic [2:0] CW_CLOSE  = 3'd2;
  localparam logic [2:0] CW_OPEN   = 3'd3;
  localparam logic [2:0] CW_TCLOSE = 3'd4;
  localparam logic [2:0] CW_TOPEN  = 3'd5;

  localparam logic [2:0] START_NONE  = 3'd0;
  localparam logic [2:0] START_CLOSE = 3'd1;
  localparam logic [2:0] START_OPEN  = 3'd2;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_STOP  = 3'd1;
  localparam logic [2:0] EV_CLOSE = 3'd2;
  localparam logic [2:0] EV_OPEN  = 3'd3;
  localparam logic [2:0] EV_MOVE  = 3'd4;

  localparam logic [1:0] ORG_NONE    = 2'd0;
  localparam logic [1:0] ORG_PANEL   = 2'd1;
  localparam logic [1:0] ORG_DIGITAL = 2'd2;

  localparam logic [4:0] SRC_SERIAL  = 5'b00001;
  localparam logic [4:0] SRC_DIGITAL = 5'b00010;
  localparam logic [4:0] SRC_RPANEL  = 5'b00100;
  localparam logic [4:0] SRC_LPANEL  = 5'b01000;
  localparam logic [4:0] SRC_ANALOG  = 5'b10000;

  localparam logic [31:0] INT32_MAX = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_EXEC
  } back_state_e;

  typedef struct packed {
    logic [1:0]  control_mode;
    logic [1:0]  remote_source;
    logic [1:0]  break_mode;
    logic [31:0] full_travel;
    logic [15:0] dead_band;
    logic [15:0] break_extra;
    logic        seal_unlocked;
    logic        local_digital;
  } cfg_t;

  // classified tick as it travels from front to back
  typedef struct packed {
    logic        local_mode;
    logic [4:0]  active_sources;
    logic [1:0]  panel_key;
    logic [3:0]  remote_bits;
    logic [2:0]  serial_cmd;
    logic [5:0]  drive_status;
    logic        calibrated;
    logic [9:0]  setpoint;
    logic [31:0] measured_pos;
  } item_t;

  typedef struct packed {
    logic [2:0]  start_cmd;
    logic        stop_pulse;
    logic [31:0] target_pos;
    logic        target_known;
    logic        break_active;
    logic [2:0]  event_code;
    logic [1:0]  event_origin;
    logic        local_mode;
    logic [4:0]  active_sources;
    logic        panel_refused;
    logic        end_ignored;
    logic        remote_armed;
  } res_t;

endpackage

### rtl/core/vca_front.sv
// vca_front: accepts ticks, works out local/remote mode and active sources
// depends on vca_pkg
module vca_front (
  input  vca_pkg::cfg_t  cfg_i,
  input  logic           push_i,
  input  logic           q_full_i,
  input  logic           local_select_i,
  input  logic [1:0]     panel_key_i,
  input  logic [3:0]     remote_bits_i,
  input  logic [2:0]     serial_cmd_i,
  input  logic [5:0]     drive_status_i,
  input  logic           calibrated_i,
  input  logic [9:0]     setpoint_i,
  input  logic [31:0]    measured_pos_i,
  output logic           q_push_o,
  output vca_pkg::item_t q_item_o
);
  import vca_pkg::*;

  logic       local_m;
  logic [4:0] act;
  logic [4:0] dig;

  always_comb begin
    local_m = 1'b0;
    case (cfg_i.control_mode)
      MODE_SWITCH: local_m = local_select_i;
      MODE_LOCAL:  local_m = 1'b1;
      default:     local_m = 1'b0;
    endcase
    dig = cfg_i.local_digital ? 5'b0 : SRC_DIGITAL;
    act = 5'b0;
    if (cfg_i.control_mode == MODE_ANALOG) begin
      act = SRC_ANALOG;
    end else if (local_m) begin
      act = SRC_RPANEL | SRC_LPANEL | (cfg_i.local_digital ? SRC_DIGITAL : 5'b0);
    end else begin
      case (cfg_i.remote_source)
        RSRC_BOTH:    act = dig | SRC_SERIAL;
        RSRC_DIGITAL: act = dig;
        RSRC_SERIAL:  act = SRC_SERIAL;
        default:      act = 5'b0;
      endcase
    end
  end

  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    q_item_o.local_mode     = local_m;
    q_item_o.active_sources = act;
    q_item_o.panel_key      = panel_key_i;
    q_item_o.remote_bits    = remote_bits_i;
    q_item_o.serial_cmd     = serial_cmd_i;
    q_item_o.drive_status   = drive_status_i;
    q_item_o.calibrated     = calibrated_i;
    q_item_o.setpoint       = setpoint_i;
    q_item_o.measured_pos   = measured_pos_i;
  end

endmodule

### rtl/core/vca_queue.sv
// vca_queue: two-entry register queue between front and back
// depends on vca_pkg
module vca_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vca_pkg::item_t item_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output vca_pkg::item_t item_o
);
  import vca_pkg::*;

  item_t      mem_q [QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'(QDepth));
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(QDepth)) else $error("queue count out of range");

endmodule

### rtl/core/vca_back.sv
// vca_back: scales the analog setpoint, arbitrates and executes the control word
// depends on vca_pkg
module vca_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vca_pkg::cfg_t  cfg_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  vca_pkg::item_t q_item_i,
  output logic           res_valid_o,
  input  logic           res_pop_i,
  output vca_pkg::res_t  res_o
);
  import vca_pkg::*;

  back_state_e state_q, state_d;
  item_t       item_q;
  logic [41:0] prod_q;
  logic [32:0] pos_q;
  res_t        res_q;
  logic        res_valid_q, res_valid_d;

  logic [31:0] target_q, target_d;
  logic        known_q, known_d;
  logic        brk_q, brk_d;
  logic [2:0]  ev_q, ev_d;
  logic [1:0]  org_q, org_d;
  logic        refused_q, refused_d;
  logic        ignored_q, ignored_d;
  logic        armed_q, armed_d;

  logic        latch, commit, res_free;
  logic [2:0]  start;
  logic        stop;

  assign res_free = !res_valid_q || res_pop_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_EXEC;
      ST_EXEC: if (res_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    latch  = 1'b0;
    commit = 1'b0;
    case (state_q)
      ST_IDLE: latch = !q_empty_i;
      ST_EXEC: commit = res_free;
      default: ;
    endcase
  end

  assign q_pop_o = latch;

  // arbitration and execution
  always_comb begin
    logic [2:0]  cw;
    logic [2:0]  tu;
    logic        rdy;
    logic [5:0]  st;
    logic signed [34:0] pos_s, mpos_s, db_s;
    logic [1:0]  mv;
    logic        closing, test, at_end, brk_en;
    logic [32:0] sum;
    st        = item_q.drive_status;
    cw        = item_q.serial_cmd;
    tu        = CW_NONE;
    rdy       = 1'b0;
    target_d  = target_q;
    known_d   = known_q;
    brk_d     = brk_q;
    ev_d      = ev_q;
    org_d     = org_q;
    refused_d = refused_q;
    ignored_d = ignored_q;
    armed_d   = armed_q;
    start     = START_NONE;
    stop      = 1'b0;

    // remote digital inputs
    if ((item_q.active_sources & SRC_DIGITAL) == 5'b0) begin
      armed_d = 1'b1;
    end else begin
      rdy = st[0] && armed_q;
      case (item_q.remote_bits[1:0])
        2'd1:    if (rdy) tu = CW_CLOSE;
        2'd2:    if (rdy) tu = CW_OPEN;
        2'd3:    tu = CW_STOP;
        default: armed_d = 1'b1;
      endcase
      if (item_q.remote_bits[3:2] != 2'b0) tu = CW_STOP;
      if (tu != CW_NONE) begin
        cw    = tu;
        org_d = ORG_DIGITAL;
      end
    end

    // panel key
    if (item_q.local_mode && item_q.panel_key != KEY_NONE) begin
      org_d = ORG_PANEL;
      if (item_q.panel_key == KEY_HALT) cw = CW_STOP;
      else if ((item_q.active_sources & SRC_LPANEL) != 5'b0) cw = {1'b0, item_q.panel_key};
      else refused_d = 1'b1;
    end

    // analog positioning against the dead band
    pos_s  = $signed({2'b00, pos_q});
    mpos_s = $signed({{3{item_q.measured_pos[31]}}, item_q.measured_pos});
    db_s   = $signed({19'b0, cfg_i.dead_band});
    mv     = 2'd0;
    if (pos_s < mpos_s - db_s) mv = START_CLOSE[1:0];
    if (pos_s > mpos_s + db_s) mv = START_OPEN[1:0];
    if (cfg_i.control_mode == MODE_ANALOG && item_q.calibrated && st[0] && !st[1]
        && mv != 2'd0) begin
      brk_d    = 1'b0;
      target_d = (pos_q[32:31] != 2'b0) ? INT32_MAX : pos_q[31:0];
      known_d  = 1'b1;
      ev_d     = EV_MOVE;
      start    = {1'b0, mv};
    end

    closing = (cw == CW_CLOSE) || (cw == CW_TCLOSE);
    test    = (cw == CW_TCLOSE) || (cw == CW_TOPEN);
    at_end  = closing ? st[2] : st[3];
    brk_en  = closing ? cfg_i.break_mode[0] : cfg_i.break_mode[1];
    sum     = {1'b0, cfg_i.full_travel} + {17'b0, cfg_i.break_extra};
    case (cw)
      CW_STOP: begin
        brk_d = 1'b0;
        if (st[1] || !cfg_i.seal_unlocked) armed_d = 1'b0;
        known_d   = 1'b0;
        target_d  = 32'b0;
        ignored_d = 1'b0;
        ev_d      = EV_STOP;
        stop      = 1'b1;
        start     = START_NONE;
      end
      CW_CLOSE, CW_OPEN, CW_TCLOSE, CW_TOPEN: begin
        if (at_end && !test) begin
          ignored_d = 1'b1;
        end else if (!(st[4] || st[5])) begin
          brk_d = 1'b0;
          if (test || !item_q.calibrated) begin
            known_d  = 1'b0;
            target_d = 32'b0;
          end else if (!brk_en) begin
            known_d  = 1'b1;
            target_d = closing ? 32'b0
                     : (cfg_i.full_travel[31] ? INT32_MAX : cfg_i.full_travel);
          end else begin
            brk_d    = 1'b1;
            known_d  = 1'b1;
            target_d = closing ? (32'b0 - {16'b0, cfg_i.break_extra})
                     : ((sum[32:31] != 2'b0) ? INT32_MAX : sum[31:0]);
          end
          ev_d  = closing ? EV_CLOSE : EV_OPEN;
          start = cw - 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_d = commit ? 1'b1 : (res_pop_i ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      target_q    <= 32'b0;
      known_q     <= 1'b0;
      brk_q       <= 1'b0;
      ev_q        <= EV_NONE;
      org_q       <= ORG_NONE;
      refused_q   <= 1'b0;
      ignored_q   <= 1'b0;
      armed_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (commit) begin
        target_q  <= target_d;
        known_q   <= known_d;
        brk_q     <= brk_d;
        ev_q      <= ev_d;
        org_q     <= org_d;
        refused_q <= refused_d;
        ignored_q <= ignored_d;
        armed_q   <= armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch) item_q <= q_item_i;
    prod_q <= cfg_i.full_travel * {22'b0, item_q.setpoint};
    pos_q  <= 33'(prod_q[41:ScaleShift] * 8'(ScaleMul));
    if (commit) begin
      res_q.start_cmd      <= start;
      res_q.stop_pulse     <= stop;
      res_q.target_pos     <= known_d ? target_d : 32'b0;
      res_q.target_known   <= known_d;
      res_q.break_active   <= brk_d;
      res_q.event_code     <= ev_d;
      res_q.event_origin   <= org_d;
      res_q.local_mode     <= item_q.local_mode;
      res_q.active_sources <= item_q.active_sources;
      res_q.panel_refused  <= refused_d;
      res_q.end_ignored    <= ignored_d;
      res_q.remote_armed   <= armed_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL1 |=> state_q == ST_MUL2) else $error("multiply sequence broken");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_pop_i |=> res_valid_q && $stable(res_q))
    else $error("waiting result changed");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.target_known |-> res_q.target_pos == 32'b0)
    else $error("unknown target not zero");

  a_stop_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.stop_pulse |-> res_q.start_cmd == START_NONE)
    else $error("stop with start");

endmodule

### rtl/core/valve_command_arbiter_top.sv
// valve_command_arbiter_top: configuration registers, front, queue and back
// depends on vca_pkg, vca_front, vca_queue, vca_back
//
// usage: one control tick goes in per push; an item is taken at a clock edge
// with push_i high and full_o low. each tick yields exactly one result, shown
// on the result ports while empty_o is low and taken with pop_i high.
// the front classifies the tick (local/remote mode, active sources) in the
// cycle of the push and writes it into a two-entry queue. the back takes one
// entry at a time and fetches the next only after the result is registered:
// its sequencer fetches the entry (ST_IDLE), scales the setpoint with its two
// multipliers (ST_MUL1, ST_MUL2), then arbitrates and executes (ST_EXEC).
// a waiting result holds while pop_i is low; the back then stalls in its
// execute step, the queue fills and full_o rises after two more ticks.
// configuration writes (cfg_valid_i, cfg_ready_o always high) are taken at any
// time and must only be made while the block is idle.
// reset clears the queue and the result valid flag and loads the register defaults.
module valve_command_arbiter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic        local_select_i,
  input  logic [1:0]  panel_key_i,
  input  logic [3:0]  remote_bits_i,
  input  logic [2:0]  serial_cmd_i,
  input  logic [5:0]  drive_status_i,
  input  logic        calibrated_i,
  input  logic [9:0]  setpoint_i,
  input  logic [31:0] measured_pos_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  start_cmd_o,
  output logic        stop_pulse_o,
  output logic [31:0] target_pos_o,
  output logic        target_known_o,
  output logic        break_active_o,
  output logic [2:0]  event_code_o,
  output logic [1:0]  event_origin_o,
  output logic        local_mode_o,
  output logic [4:0]  active_sources_o,
  output logic        panel_refused_o,
  output logic        end_ignored_o,
  output logic        remote_armed_o
);
  import vca_pkg::*;

  cfg_t  cfg_q;
  item_t f_item, b_item;
  logic  f_push, q_full, q_empty, q_pop;
  logic  res_valid;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_mode  <= MODE_SWITCH;
      cfg_q.remote_source <= RSRC_BOTH;
      cfg_q.break_mode    <= 2'd0;
      cfg_q.full_travel   <= 32'd0;
      cfg_q.dead_band     <= 16'd0;
      cfg_q.break_extra   <= 16'd0;
      cfg_q.seal_unlocked <= 1'b1;
      cfg_q.local_digital <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CONTROL_MODE:  cfg_q.control_mode  <= cfg_data_i[1:0];
        REG_REMOTE_SOURCE: cfg_q.remote_source <= cfg_data_i[1:0];
        REG_BREAK_MODE:    cfg_q.break_mode    <= cfg_data_i[1:0];
        REG_FULL_TRAVEL:   cfg_q.full_travel   <= cfg_data_i;
        REG_DEAD_BAND:     cfg_q.dead_band     <= cfg_data_i[15:0];
        REG_BREAK_EXTRA:   cfg_q.break_extra   <= cfg_data_i[15:0];
        REG_SEAL_UNLOCKED: cfg_q.seal_unlocked <= cfg_data_i[0];
        REG_LOCAL_DIGITAL: cfg_q.local_digital <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vca_front u_front (
    .cfg_i          (cfg_q),
    .push_i         (push_i),
    .q_full_i       (q_full),
    .local_select_i (local_select_i),
    .panel_key_i    (panel_key_i),
    .remote_bits_i  (remote_bits_i),
    .serial_cmd_i   (serial_cmd_i),
    .drive_status_i (drive_status_i),
    .calibrated_i   (calibrated_i),
    .setpoint_i     (setpoint_i),
    .measured_pos_i (measured_pos_i),
    .q_push_o       (f_push),
    .q_item_o       (f_item)
  );

  vca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .item_o  (b_item)
  );

  vca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_item_i    (b_item),
    .res_valid_o (res_valid),
    .res_pop_i   (pop_i),
    .res_o       (res)
  );

  assign full_o           = q_full;
  assign empty_o          = !res_valid;
  assign start_cmd_o      = res.start_cmd;
  assign stop_pulse_o     = res.stop_pulse;
  assign target_pos_o     = res.target_pos;
  assign target_known_o   = res.target_known;
  assign break_active_o   = res.break_active;
  assign event_code_o     = res.event_code;
  assign event_origin_o   = res.event_origin;
  assign local_mode_o     = res.local_mode;
  assign active_sources_o = res.active_sources;
  assign panel_refused_o  = res.panel_refused;
  assign end_ignored_o    = res.end_ignored;
  assign remote_armed_o   = res.remote_armed;

endmodule

### test/tb_valve_command_arbiter_top.sv
// tb_valve_command_arbiter_top: self-checking bench for the valve command arbiter
// predicts each tick's result in a scoreboard class and checks the result stream
// depends on vca_pkg and valve_command_arbiter_top
module tb_valve_command_arbiter_top;
  import vca_pkg::*;

  // drive status bit positions
  localparam int StStopped = 0;
  localparam int StFault   = 1;
  localparam int StClosed  = 2;
  localparam int StOpened  = 3;
  localparam int StClosing = 4;
  localparam int StOpening = 5;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic               local_select;
    logic [1:0]         panel_key;
    logic [3:0]         remote_bits;
    logic [2:0]         serial_cmd;
    logic [5:0]         drive_status;
    logic               calibrated;
    logic [9:0]         setpoint;
    logic signed [31:0] measured_pos;
  } tick_t;

  function automatic longint scaled_setpoint(logic [31:0] travel, logic [9:0] sp);
    longint prod;
    prod = longint'(travel) * longint'(sp);
    return (prod >>> ScaleShift) * ScaleMul;
  endfunction

  class valve_scoreboard;
    cfg_t   cfg;
    longint tgt;
    bit     known, brk, refused, ignored, armed;
    bit [2:0] ev;
    bit [1:0] org;
    res_t   expected_q[$];
    int     errors;
    int     checked;

    function void reset_state();
      cfg = '0;
      cfg.control_mode = MODE_SWITCH;
      cfg.seal_unlocked = 1'b1;
      tgt = 0; known = 0; brk = 0; refused = 0; ignored = 0; armed = 1;
      ev = EV_NONE; org = ORG_NONE;
      expected_q.delete();
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] val);
      case (idx)
        REG_CONTROL_MODE:  cfg.control_mode  = val[1:0];
        REG_REMOTE_SOURCE: cfg.remote_source = val[1:0];
        REG_BREAK_MODE:    cfg.break_mode    = val[1:0];
        REG_FULL_TRAVEL:   cfg.full_travel   = val;
        REG_DEAD_BAND:     cfg.dead_band     = val[15:0];
        REG_BREAK_EXTRA:   cfg.break_extra   = val[15:0];
        REG_SEAL_UNLOCKED: cfg.seal_unlocked = val[0];
        REG_LOCAL_DIGITAL: cfg.local_digital = val[0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_request(tick_t t);
      res_t   r;
      bit     local_on, analog, ready, closing, test_move;
      logic [4:0] act;
      logic [2:0] cw, from_digital, start;
      bit     stop;
      longint pos, mpos;
      logic [5:0] st;
      st = t.drive_status;
      cw = t.serial_cmd;
      start = START_NONE; stop = 0; from_digital = CW_NONE; act = '0;
      analog = (cfg.control_mode == MODE_ANALOG);
      local_on = (cfg.control_mode == MODE_SWITCH) ? t.local_select
                                                    : (cfg.control_mode == MODE_LOCAL);
      if (analog) act = SRC_ANALOG;
      else if (local_on) begin
        act = SRC_RPANEL | SRC_LPANEL | (cfg.local_digital ? SRC_DIGITAL : 5'b0);
      end else begin
        case (cfg.remote_source)
          RSRC_BOTH:    act = SRC_SERIAL | (cfg.local_digital ? 5'b0 : SRC_DIGITAL);
          RSRC_DIGITAL: act = cfg.local_digital ? 5'b0 : SRC_DIGITAL;
          RSRC_SERIAL:  act = SRC_SERIAL;
          default:      act = '0;
        endcase
      end

      if ((act & SRC_DIGITAL) == 0) armed = 1;
      else begin
        ready = st[StStopped] && armed;
        if (t.remote_bits[0] && t.remote_bits[1]) from_digital = CW_STOP;
        else if (t.remote_bits[0]) begin
          if (ready) from_digital = CW_CLOSE;
        end else if (t.remote_bits[1]) begin
          if (ready) from_digital = CW_OPEN;
        end else armed = 1;
        if (t.remote_bits[3:2] != 0) from_digital = CW_STOP;
        if (from_digital != CW_NONE) begin
          cw = from_digital;
          org = ORG_DIGITAL;
        end
      end

      if (local_on && t.panel_key != KEY_NONE) begin
        org = ORG_PANEL;
        if (t.panel_key == KEY_HALT) cw = CW_STOP;
        else if ((act & SRC_LPANEL) != 0) cw = {1'b0, t.panel_key};
        else refused = 1;
      end

      if (analog && t.calibrated && st[StStopped] && !st[StFault]) begin
        pos = scaled_setpoint(cfg.full_travel, t.setpoint);
        mpos = longint'(t.measured_pos);
        if (pos < mpos - longint'(cfg.dead_band)) start = START_CLOSE;
        if (pos > mpos + longint'(cfg.dead_band)) start = START_OPEN;
        if (start != START_NONE) begin
          brk = 0; tgt = sat(pos); known = 1; ev = EV_MOVE;
        end
      end

      if (cw == CW_STOP) begin
        brk = 0;
        if (st[StFault] || !cfg.seal_unlocked) armed = 0;
        known = 0; tgt = 0; ignored = 0; ev = EV_STOP;
        stop = 1; start = START_NONE;
      end else if (cw >= CW_CLOSE && cw <= CW_TOPEN) begin
        closing = (cw == CW_CLOSE || cw == CW_TCLOSE);
        test_move = (cw >= CW_TCLOSE);
        if ((closing ? st[StClosed] : st[StOpened]) && !test_move) ignored = 1;
        else if (!(st[StClosing] || st[StOpening])) begin
          brk = 0;
          if (test_move || !t.calibrated) begin
            known = 0; tgt = 0;
          end else if (!(closing ? cfg.break_mode[0] : cfg.break_mode[1])) begin
            known = 1;
            tgt = closing ? 0 : sat(longint'(cfg.full_travel));
          end else begin
            brk = 1; known = 1;
            tgt = closing ? -longint'(cfg.break_extra)
                          : sat(longint'(cfg.full_travel) + longint'(cfg.break_extra));
          end
          ev = closing ? EV_CLOSE : EV_OPEN;
          start = cw - 3'd1;
        end
      end

      r.start_cmd      = start;
      r.stop_pulse     = stop;
      r.target_pos     = known ? tgt[31:0] : 32'd0;
      r.target_known   = known;
      r.break_active   = brk;
      r.event_code     = ev;
      r.event_origin   = org;
      r.local_mode     = local_on;
      r.active_sources = act;
      r.panel_refused  = refused;
      r.end_ignored    = ignored;
      r.remote_armed   = armed;
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      cmp("start_cmd", e.start_cmd, a.start_cmd);
      cmp("stop_pulse", e.stop_pulse, a.stop_pulse);
      cmp("target_pos", e.target_pos, a.target_pos);
      cmp("target_known", e.target_known, a.target_known);
      cmp("break_active", e.break_active, a.break_active);
      cmp("event_code", e.event_code, a.event_code);
      cmp("event_origin", e.event_origin, a.event_origin);
      cmp("local_mode", e.local_mode, a.local_mode);
      cmp("active_sources", e.active_sources, a.active_sources);
      cmp("panel_refused", e.panel_refused, a.panel_refused);
      cmp("end_ignored", e.end_ignored, a.end_ignored);
      cmp("remote_armed", e.remote_armed, a.remote_armed);
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        push_i, full_o, empty_o, pop_i;
  tick_t       tick_d;
  res_t        res_q;

  valve_command_arbiter_top DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push_i, .full_o,
    .local_select_i (tick_d.local_select),
    .panel_key_i    (tick_d.panel_key),
    .remote_bits_i  (tick_d.remote_bits),
    .serial_cmd_i   (tick_d.serial_cmd),
    .drive_status_i (tick_d.drive_status),
    .calibrated_i   (tick_d.calibrated),
    .setpoint_i     (tick_d.setpoint),
    .measured_pos_i (tick_d.measured_pos),
    .empty_o, .pop_i,
    .start_cmd_o      (res_q.start_cmd),
    .stop_pulse_o     (res_q.stop_pulse),
    .target_pos_o     (res_q.target_pos),
    .target_known_o   (res_q.target_known),
    .break_active_o   (res_q.break_active),
    .event_code_o     (res_q.event_code),
    .event_origin_o   (res_q.event_origin),
    .local_mode_o     (res_q.local_mode),
    .active_sources_o (res_q.active_sources),
    .panel_refused_o  (res_q.panel_refused),
    .end_ignored_o    (res_q.end_ignored),
    .remote_armed_o   (res_q.remote_armed)
  );

  valve_scoreboard sb;
  bit quiet;
  int cycles;
  int sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_valve_command_arbiter_top: done, errors");
      $finish;
    end
  end

  // result side: random stall bursts, none once quiet
  initial begin
    int stall;
    stall = 0;
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) sb.check_result(res_q);
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 17);
      pop_i <= (stall == 0);
    end
  end

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_tick(tick_t t);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    tick_d <= t;
    forever begin
      @(posedge clk_i);
      if (!full_o) break;
    end
    sb.note_request(t);
    sent++;
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    longint pos;
    t = tick_t'({$urandom, $urandom});
    t.serial_cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
    t.setpoint = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1000));
    // mostly a healthy stopped drive so analog and command moves get through
    if ($urandom_range(0, 2) != 0) begin
      t.drive_status = 6'(1 << StStopped);
      if ($urandom_range(0, 2) == 0) t.drive_status[StClosed] = 1'b1;
      else if ($urandom_range(0, 2) == 0) t.drive_status[StOpened] = 1'b1;
      t.calibrated = 1'b1;
    end
    if ($urandom_range(0, 3) == 0) t.remote_bits = 4'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) begin
      pos = scaled_setpoint(sb.cfg.full_travel, t.setpoint);
      t.measured_pos = 32'(pos + longint'($urandom_range(0, 400)) - 200);
    end
    return t;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_tick(random_tick());
    push_i <= 1'b0;
    wait_drained();
  endtask

  task automatic random_config();
    write_reg(REG_CONTROL_MODE, $urandom_range(0, 3));
    write_reg(REG_REMOTE_SOURCE, $urandom_range(0, 3));
    write_reg(REG_BREAK_MODE, $urandom_range(0, 3));
    write_reg(REG_FULL_TRAVEL, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000));
    write_reg(REG_DEAD_BAND, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 150));
    write_reg(REG_BREAK_EXTRA, $urandom_range(0, 65535));
    write_reg(REG_SEAL_UNLOCKED, $urandom_range(0, 1));
    write_reg(REG_LOCAL_DIGITAL, $urandom_range(0, 1));
  endtask

  initial begin
    tick_t t;
    sb = new();
    sb.reset_state();
    quiet = 0; cycles = 0; sent = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    push_i = 1'b0; tick_d = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: panel keys, remote bits, serial codes, end stops, extremes
    for (int i = 0; i < 8; i++) begin
      t = '0;
      t.local_select = i[0];
      t.panel_key = 2'(i >> 1);
      t.serial_cmd = 3'(i);
      t.drive_status = 6'(1 << StStopped);
      t.calibrated = 1'b1;
      send_tick(t);
    end
    for (int i = 0; i < 6; i++) begin
      t = '0;
      t.remote_bits = 4'(1 << (i % 4)) | (i >= 4 ? 4'b0011 : 4'b0);
      t.drive_status = 6'(1 << i);
      t.serial_cmd = CW_TOPEN;
      t.calibrated = i[0];
      send_tick(t);
    end
    t = '1;
    send_tick(t);
    push_i <= 1'b0;
    wait_drained();

    // analog at the extremes, big travel and break-through enabled at both ends
    write_reg(REG_CONTROL_MODE, MODE_ANALOG);
    write_reg(REG_FULL_TRAVEL, 32'hffff_ffff);
    write_reg(REG_DEAD_BAND, 16'hffff);
    write_reg(REG_BREAK_EXTRA, 16'hffff);
    write_reg(REG_BREAK_MODE, 2'd3);
    write_reg(REG_SEAL_UNLOCKED, 1'b0);
    write_reg(REG_LOCAL_DIGITAL, 1'b1);
    write_reg(REG_REMOTE_SOURCE, 2'd3);
    for (int i = 0; i < 4; i++) begin
      t = '0;
      t.drive_status = 6'(1 << StStopped);
      t.calibrated = 1'b1;
      t.setpoint = (i < 2) ? 10'd1023 : 10'd0;
      t.measured_pos = i[0] ? 32'h8000_0000 : 32'h7fff_ffff;
      t.serial_cmd = (i == 3) ? CW_OPEN : CW_NONE;
      send_tick(t);
    end
    random_phase(40);

    for (int p = 0; p < 8; p++) begin
      random_config();
      if (p == 7) quiet = 1;
      random_phase(70);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("%0d ticks sent, %0d results checked across 10 register settings",
             sent, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb_valve_command_arbiter_top: done, clean");
    else
      $display("tb_valve_command_arbiter_top: done, errors");
    $finish;
  end
endmodule
